[hdl/mcg_pkg.sv]
// Package for the midpoint circle generator.
// Holds the job record, field widths and command codes shared by all modules.
// No dependencies.
`default_nettype none

package mcg_pkg;

  localparam int CoordBitsDefault = 16;
  localparam int OffBits          = 15;
  localparam int RadiusBits       = 14;
  localparam int DecBits          = 20;
  localparam int PointBits        = 16;
  localparam int SumBits          = 17;
  localparam int PointsPerStep    = 8;
  localparam int StepBits         = 3;
  localparam int QueueDepth       = 2;
  localparam int InDataBits       = 48;
  localparam int OutDataBits      = 32;
  localparam int OutUserBits      = 2;

  localparam logic CmdStart   = 1'b0;
  localparam logic CmdAdvance = 1'b1;

  localparam int UserDoneBit = 0;
  localparam int UserIdleBit = 1;

  typedef struct packed {
    logic signed [OffBits-1:0] cx;
    logic signed [OffBits-1:0] cy;
    logic signed [OffBits-1:0] a;
    logic signed [OffBits-1:0] b;
    logic                      done;
    logic                      idle;
  } job_t;

endpackage

`default_nettype wire

[hdl/mcg_front.sv]
// Front end of the midpoint circle generator: takes commands and keeps the
// circle state, issuing one job per advance to the job queue.
// Depends on mcg_pkg.
`default_nettype none

module mcg_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [mcg_pkg::InDataBits-1:0] s_axis_tdata,
  input  wire logic [0:0]                    s_axis_tuser,
  input  wire logic                          full_i,
  output logic                               push_o,
  output mcg_pkg::job_t                      job_o
);

  logic                                    accept;
  logic                                    is_start;
  logic [mcg_pkg::RadiusBits-1:0]          radius;
  logic signed [mcg_pkg::OffBits-1:0]      cx_q, cx_d, cy_q, cy_d;
  logic signed [mcg_pkg::OffBits-1:0]      a_q, a_d, b_q, b_d;
  logic [mcg_pkg::DecBits-1:0]             d_q, d_d;
  logic                                    active_q, active_d;
  logic signed [mcg_pkg::OffBits-1:0]      na, nb;
  logic [mcg_pkg::OffBits:0]               diff;
  logic [mcg_pkg::DecBits-1:0]             a_ext, diff_ext, nd;
  logic                                    done;

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_start      = (s_axis_tuser[0] == mcg_pkg::CmdStart);
  assign radius        = s_axis_tdata[43:30];

  always_comb begin
    a_ext    = {{(mcg_pkg::DecBits-mcg_pkg::OffBits){a_q[mcg_pkg::OffBits-1]}}, a_q};
    diff     = {a_q[mcg_pkg::OffBits-1], a_q} - {b_q[mcg_pkg::OffBits-1], b_q};
    diff_ext = {{(mcg_pkg::DecBits-mcg_pkg::OffBits-1){diff[mcg_pkg::OffBits]}}, diff};
    na       = a_q + mcg_pkg::OffBits'(1);
    if (d_q[mcg_pkg::DecBits-1]) begin
      nd = d_q + (a_ext << 2) + mcg_pkg::DecBits'(6);
      nb = b_q;
    end else begin
      nd = d_q + (diff_ext << 2) + mcg_pkg::DecBits'(10);
      nb = b_q - mcg_pkg::OffBits'(1);
    end
    done = (na > nb);
  end

  always_comb begin
    cx_d     = cx_q;
    cy_d     = cy_q;
    a_d      = a_q;
    b_d      = b_q;
    d_d      = d_q;
    active_d = active_q;
    push_o   = 1'b0;
    job_o    = '0;
    if (accept) begin
      if (is_start) begin
        cx_d     = s_axis_tdata[14:0];
        cy_d     = s_axis_tdata[29:15];
        a_d      = '0;
        b_d      = {1'b0, radius};
        d_d      = mcg_pkg::DecBits'(3) - {5'd0, radius, 1'b0};
        active_d = 1'b1;
      end else if (active_q) begin
        push_o     = 1'b1;
        job_o.cx   = cx_q;
        job_o.cy   = cy_q;
        job_o.a    = a_q;
        job_o.b    = b_q;
        job_o.done = done;
        a_d        = na;
        b_d        = nb;
        d_d        = nd;
        active_d   = !done;
      end else begin
        push_o     = 1'b1;
        job_o.idle = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      a_q      <= '0;
      b_q      <= '0;
      d_q      <= '0;
      active_q <= 1'b0;
    end else begin
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      a_q      <= a_d;
      b_q      <= b_d;
      d_q      <= d_d;
      active_q <= active_d;
    end
  end

endmodule

`default_nettype wire

[hdl/mcg_queue.sv]
// Short job queue between the front and back ends of the circle generator.
// Register-based FIFO with show-ahead read. Depends on mcg_pkg.
`default_nettype none

module mcg_queue #(
  parameter int Width = $bits(mcg_pkg::job_t),
  parameter int Depth = mcg_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  valid_o,
  output logic                  full_o
);

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntBits-1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntBits'(Depth));
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrBits'(Depth - 1)) ? '0 : wr_q + PtrBits'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrBits'(Depth - 1)) ? '0 : rd_q + PtrBits'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job queue read while empty");

endmodule

`default_nettype wire

[hdl/mcg_back.sv]
// Back end of the circle generator: turns each queued job into its eight
// mirrored points (an idle job into one zero point), one per cycle when
// not stalled, through a registered output stage. Depends on mcg_pkg.
`default_nettype none

module mcg_back #(
  parameter int COORD_BITS = mcg_pkg::CoordBitsDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mcg_pkg::job_t                    job_i,
  input  wire logic                             job_valid_i,
  output logic                                  pop_o,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [mcg_pkg::OutDataBits-1:0]       m_axis_tdata,
  output logic                                  m_axis_tlast,
  output logic [mcg_pkg::OutUserBits-1:0]       m_axis_tuser
);

  localparam int WrapBits = (COORD_BITS < mcg_pkg::PointBits) ? COORD_BITS
                                                              : mcg_pkg::PointBits;
  localparam logic [mcg_pkg::StepBits-1:0] LastStep =
    mcg_pkg::StepBits'(mcg_pkg::PointsPerStep - 1);

  mcg_pkg::job_t                       cur_q;
  logic                                cur_valid_q;
  logic [mcg_pkg::StepBits-1:0]        step_q;
  logic                                emit, cur_last;
  logic signed [mcg_pkg::OffBits-1:0]  u, v;
  logic [mcg_pkg::SumBits-1:0]         sum_x, sum_y;
  logic [mcg_pkg::PointBits-1:0]       px, py;
  logic                                m_valid_q;
  logic [mcg_pkg::OutDataBits-1:0]     m_data_q;
  logic                                m_last_q;
  logic [mcg_pkg::OutUserBits-1:0]     m_user_q;

  assign emit     = cur_valid_q && (!m_valid_q || m_axis_tready);
  assign cur_last = cur_q.idle || (step_q == LastStep);
  assign pop_o    = job_valid_i && (!cur_valid_q || (emit && cur_last));

  always_comb begin
    u = step_q[2] ? cur_q.b : cur_q.a;
    v = step_q[2] ? cur_q.a : cur_q.b;
    if (step_q[1]) begin
      sum_x = {{2{cur_q.cx[mcg_pkg::OffBits-1]}}, cur_q.cx} - {{2{u[mcg_pkg::OffBits-1]}}, u};
    end else begin
      sum_x = {{2{cur_q.cx[mcg_pkg::OffBits-1]}}, cur_q.cx} + {{2{u[mcg_pkg::OffBits-1]}}, u};
    end
    if (step_q[0]) begin
      sum_y = {{2{cur_q.cy[mcg_pkg::OffBits-1]}}, cur_q.cy} - {{2{v[mcg_pkg::OffBits-1]}}, v};
    end else begin
      sum_y = {{2{cur_q.cy[mcg_pkg::OffBits-1]}}, cur_q.cy} + {{2{v[mcg_pkg::OffBits-1]}}, v};
    end
    for (int i = 0; i < mcg_pkg::PointBits; i++) begin
      px[i] = (i < WrapBits) ? sum_x[i] : sum_x[WrapBits-1];
      py[i] = (i < WrapBits) ? sum_y[i] : sum_y[WrapBits-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= '0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      step_q      <= '0;
    end else if (emit && cur_last) begin
      cur_valid_q <= 1'b0;
    end else if (emit) begin
      step_q <= step_q + mcg_pkg::StepBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q                        <= cur_q.idle ? '0 : {py, px};
      m_last_q                        <= cur_last;
      m_user_q[mcg_pkg::UserDoneBit]  <= cur_q.done && !cur_q.idle && (step_q == LastStep);
      m_user_q[mcg_pkg::UserIdleBit]  <= cur_q.idle;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[mcg_pkg::UserDoneBit] |-> m_axis_tlast)
    else $error("circle done flagged on a point that is not last");

  a_idle_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[mcg_pkg::UserIdleBit] |->
      m_axis_tlast && (m_axis_tdata == '0) && !m_axis_tuser[mcg_pkg::UserDoneBit])
    else $error("idle result is not a single zero point");

  a_step_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !cur_last |=> cur_valid_q && (step_q == $past(step_q) + mcg_pkg::StepBits'(1)))
    else $error("point step did not advance");

endmodule

`default_nettype wire

[hdl/midpoint_circle_generator_core.sv]
// Top level of the midpoint circle generator: front end, job queue, back end.
// Depends on mcg_pkg, mcg_front, mcg_queue and mcg_back.
//
// Channel  Dir  Handshake              Content
// s_axis   in   tvalid/tready          tuser: cmd; tdata: center_x, center_y, radius
// m_axis   out  tvalid/tready, tlast   tdata: point_x, point_y; tuser: done, idle
//
// A start takes one input transfer and gives no output. An advance gives eight
// points, one per output cycle while the output is not stalled, so the output
// port limits the advance rate; an advance with no active circle gives one idle
// point. A two-job queue lets the front end keep taking commands while points
// drain. Reset clears the circle state and the queue at once; there is no init
// pass. Output stalls back up into the queue and then deassert s_axis_tready.
`default_nettype none

module midpoint_circle_generator_core #(
  parameter int COORD_BITS = mcg_pkg::CoordBitsDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // center_x [14:0], center_y [29:15], radius [43:30], zero [47:44]
  input  wire logic [mcg_pkg::InDataBits-1:0]   s_axis_tdata,
  // cmd [0]
  input  wire logic [0:0]                       s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // point_x [15:0], point_y [31:16]
  output logic [mcg_pkg::OutDataBits-1:0]       m_axis_tdata,
  output logic                                  m_axis_tlast,
  // circle_done [0], idle_result [1]
  output logic [mcg_pkg::OutUserBits-1:0]       m_axis_tuser
);

  localparam int JobBits = $bits(mcg_pkg::job_t);

  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_valid;
  mcg_pkg::job_t       push_job;
  logic [JobBits-1:0]  q_data;
  mcg_pkg::job_t       head_job;

  assign head_job = mcg_pkg::job_t'(q_data);

  mcg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (q_full),
    .push_o        (push),
    .job_o         (push_job)
  );

  mcg_queue #(
    .Width (JobBits),
    .Depth (mcg_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (JobBits'(push_job)),
    .pop_i   (pop),
    .data_o  (q_data),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  mcg_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (head_job),
    .job_valid_i   (q_valid),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire
